[rtl/core/dtpv_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helper functions of the date text parser
package dtpv_pkg;

  localparam int AccW  = 16;
  localparam int YearW = 14;
  localparam int ResW  = 5;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [AccW-1:0] ACC_MAX = 16'hFFFF;

  // field selector codes
  localparam logic [1:0] FLD_DAY   = 2'd0;
  localparam logic [1:0] FLD_MONTH = 2'd1;
  localparam logic [1:0] FLD_YEAR  = 2'd2;
  localparam logic [1:0] FLD_OVER  = 2'd3;

  // configuration register indexes
  localparam logic REG_YEAR_LO = 1'b0;
  localparam logic REG_YEAR_HI = 1'b1;

  localparam logic [YearW-1:0] YEAR_LO_RST = 14'd1;
  localparam logic [YearW-1:0] YEAR_HI_RST = 14'd9999;

  // finished string handed from the parser to the checker
  typedef struct packed {
    logic            err;
    logic [AccW-1:0] day;
    logic [AccW-1:0] month;
    logic [AccW-1:0] year;
    logic [ResW-1:0] year_r25;
  } fin_t;

  // year residue mod 25 after appending one decimal digit
  function automatic logic [ResW-1:0] r25_push(input logic [ResW-1:0] r,
                                               input logic [3:0] d);
    logic [ResW-1:0] m5;
    logic [ResW-1:0] base;
    logic [ResW-1:0] s;
    if (r >= 5'd20)      m5 = r - 5'd20;
    else if (r >= 5'd15) m5 = r - 5'd15;
    else if (r >= 5'd10) m5 = r - 5'd10;
    else if (r >= 5'd5)  m5 = r - 5'd5;
    else                 m5 = r;
    case (m5)
      5'd0:    base = 5'd0;
      5'd1:    base = 5'd10;
      5'd2:    base = 5'd20;
      5'd3:    base = 5'd5;
      5'd4:    base = 5'd15;
      default: base = 5'd0;
    endcase
    s = base + {1'b0, d};
    if (s >= 5'd25) s = s - 5'd25;
    return s;
  endfunction

  // days in a month, month already known to be 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/dtpv_parse.sv]
`timescale 1ns / 1ps
// character stage: field accumulators and capture of the finished string
module dtpv_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         char_code,
  input  logic               last,
  output logic               fin_valid,
  input  logic               fin_ready,
  output dtpv_pkg::fin_t     fin
);
  import dtpv_pkg::*;

  logic [AccW-1:0] day_acc, month_acc, year_acc;
  logic [AccW-1:0] day_acc_next, month_acc_next, year_acc_next;
  logic [1:0]      field_index, field_index_next;
  logic            error_seen, error_seen_next;
  logic [ResW-1:0] year_r25, year_r25_next;
  logic            accept;

  logic [AccW-1:0] cur;
  logic [3:0]      digit;
  logic [AccW+3:0] wide;
  logic [AccW-1:0] pushed;
  logic            is_digit;

  assign in_ready = !fin_valid || fin_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    digit    = 4'(char_code - CH_ZERO);
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    case (field_index)
      FLD_DAY:   cur = day_acc;
      FLD_MONTH: cur = month_acc;
      default:   cur = year_acc;
    endcase
    // acc * 10 + digit, saturating
    wide   = ({4'b0, cur} << 3) + ({4'b0, cur} << 1) + {16'b0, digit};
    pushed = (wide > {4'b0, ACC_MAX}) ? ACC_MAX : wide[AccW-1:0];

    day_acc_next     = day_acc;
    month_acc_next   = month_acc;
    year_acc_next    = year_acc;
    year_r25_next    = year_r25;
    field_index_next = field_index;
    error_seen_next  = error_seen;
    if (!error_seen) begin
      if (char_code == CH_SLASH) begin
        if (field_index >= FLD_YEAR) begin
          field_index_next = FLD_OVER;
          error_seen_next  = 1'b1;
        end else begin
          field_index_next = field_index + 2'd1;
        end
      end else if (!is_digit) begin
        error_seen_next = 1'b1;
      end else begin
        case (field_index)
          FLD_DAY:   day_acc_next = pushed;
          FLD_MONTH: month_acc_next = pushed;
          default: begin
            year_acc_next = pushed;
            year_r25_next = r25_push(year_r25, digit);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      day_acc     <= '0;
      month_acc   <= '0;
      year_acc    <= '0;
      year_r25    <= '0;
      field_index <= FLD_DAY;
      error_seen  <= 1'b0;
      fin_valid   <= 1'b0;
    end else begin
      fin_valid <= (accept && last) || (fin_valid && !fin_ready);
      if (accept) begin
        if (last) begin
          day_acc     <= '0;
          month_acc   <= '0;
          year_acc    <= '0;
          year_r25    <= '0;
          field_index <= FLD_DAY;
          error_seen  <= 1'b0;
        end else begin
          day_acc     <= day_acc_next;
          month_acc   <= month_acc_next;
          year_acc    <= year_acc_next;
          year_r25    <= year_r25_next;
          field_index <= field_index_next;
          error_seen  <= error_seen_next;
        end
      end
    end
  end

  // payload of the finished string, no reset needed
  always_ff @(posedge clk) begin
    if (accept && last) begin
      fin.err      <= error_seen_next;
      fin.day      <= day_acc_next;
      fin.month    <= month_acc_next;
      fin.year     <= year_acc_next;
      fin.year_r25 <= year_r25_next;
    end
  end

endmodule

[rtl/core/dtpv_check.sv]
`timescale 1ns / 1ps
// calendar check stage, year bound registers and the result register
module dtpv_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [dtpv_pkg::YearW-1:0]   cfg_data,
  input  logic                         fin_valid,
  output logic                         fin_ready,
  input  dtpv_pkg::fin_t               fin,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_ok,
  output logic [5:0]                   res_day,
  output logic [4:0]                   res_month,
  output logic [14:0]                  res_year
);
  import dtpv_pkg::*;

  logic [YearW-1:0] year_lo, year_hi;
  logic             leap, year_ok, month_ok, day_ok, ok;
  logic [4:0]       len;
  logic             move;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_lo <= YEAR_LO_RST;
      year_hi <= YEAR_HI_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YEAR_LO: year_lo <= cfg_data;
        REG_YEAR_HI: year_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // divisible by 4 and not by 100, or by 400 (i.e. by 16 and by 25)
    leap = ((fin.year[1:0] == 2'd0) && (fin.year_r25 != 5'd0)) ||
           ((fin.year[3:0] == 4'd0) && (fin.year_r25 == 5'd0));
    year_ok  = (fin.year >= {2'b0, year_lo}) && (fin.year <= {2'b0, year_hi});
    month_ok = (fin.month >= 16'd1) && (fin.month <= 16'd12);
    len      = month_len(fin.month[3:0], leap);
    day_ok   = (fin.day != '0) && (fin.day <= {11'b0, len});
    ok       = !fin.err && year_ok && month_ok && day_ok;
  end

  assign fin_ready = !res_valid || res_ready;
  assign move      = fin_valid && fin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fin_ready) begin
      res_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_ok    <= ok;
      res_day   <= ok ? fin.day[5:0]    : 6'h3F;
      res_month <= ok ? fin.month[4:0]  : 5'h1F;
      res_year  <= ok ? fin.year[14:0]  : 15'h7FFF;
    end
  end

endmodule

[rtl/core/date_text_parser_validator.sv]
`timescale 1ns / 1ps
// top level of the dd/mm/yyyy date text parser and validator
//
// takes a date string one character per word on the slave stream, with tlast
// on the final character. digits build day, month and year in turn, a slash
// moves to the next field; a third slash or any other non-digit makes the
// string invalid and the rest of it is ignored. each field saturates at 65535.
// on the final character the year is checked against the lower and upper year
// bounds (config index 0 and 1, reset 1 and 9999), the month against 1..12 and
// the day against the month length with the gregorian leap rule; one result
// word then leaves on the master stream, holding the fields or -1 in all three
// with the valid flag clear. one character is taken every cycle unless a stall
// holds it. a result passes through the character stage, whose register holds
// the finished fields, then the check stage that loads the output register.
// both stages stall only when the output is held back.
module date_text_parser_validator (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [13:0] cfg_data,
  // character stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_code
  input  logic        s_tlast,    // last character of the string
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // [0] valid_res, [6:1] day_out, [11:7] month_out,
                                  // [26:12] year_out, [31:27] zero
);
  import dtpv_pkg::*;

  fin_t        fin;
  logic        fin_valid, fin_ready;
  logic        res_ok;
  logic [5:0]  res_day;
  logic [4:0]  res_month;
  logic [14:0] res_year;

  // character stage
  dtpv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .char_code (s_tdata),
    .last      (s_tlast),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin)
  );

  // calendar check and output register
  dtpv_check u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin       (fin),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_ok    (res_ok),
    .res_day   (res_day),
    .res_month (res_month),
    .res_year  (res_year)
  );

  // pack result fields, lowest field first, zero padded to 32 bits
  assign m_tdata = {5'b0, res_year, res_month, res_day, res_ok};

endmodule

[rtl/core/dtpv_checker.sv]
`timescale 1ns / 1ps
// port level checks of the date parser, bound to the top level
module dtpv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a rejected date carries -1 in every field
  a_invalid_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[26:1] == 26'h3FFFFFF)
    else $error("invalid result without all-ones fields");

  // an accepted date has a real day and month
  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      m_tdata[6:1] != 6'd0 && m_tdata[6:1] <= 6'd31 &&
      m_tdata[11:7] != 5'd0 && m_tdata[11:7] <= 5'd12)
    else $error("valid result with day or month out of range");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:27] == 5'd0)
    else $error("padding bits set in result word");

endmodule

bind date_text_parser_validator dtpv_checker u_dtpv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of the dd/mm/yyyy date text parser and validator
module tb_top;
  import dtpv_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseChars   = 170;   // characters per bound setting
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned HoldCycles   = 300;   // long receiver hold-off
  localparam int unsigned HoldAfter    = 40;    // results seen before the hold-off
  localparam int unsigned SettleCycles = 8;     // wait after the last due date

  // one expected result word, split into its fields
  typedef struct {
    logic       ok;
    logic [5:0] day;
    logic [4:0] month;
    logic [14:0] year;
  } date_res_t;

  // tracks the parser state of the block and holds the dates still due
  class date_tracker;
    logic [AccW-1:0]  day_acc;
    logic [AccW-1:0]  month_acc;
    logic [AccW-1:0]  year_acc;
    logic [1:0]       fld;
    bit               err;
    logic [YearW-1:0] ymin;
    logic [YearW-1:0] ymax;
    date_res_t        due_dates[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      valid_seen;
    int unsigned      chars;

    function new();
      ymin = YEAR_LO_RST;
      ymax = YEAR_HI_RST;
      restart();
    endfunction

    function void restart();
      day_acc   = '0;
      month_acc = '0;
      year_acc  = '0;
      fld       = FLD_DAY;
      err       = 1'b0;
    endfunction

    function logic [AccW-1:0] append_digit(logic [AccW-1:0] acc, logic [3:0] d);
      int unsigned v;
      v = acc;
      v = v * 10 + d;
      return (v > ACC_MAX) ? ACC_MAX : v[AccW-1:0];
    endfunction

    function bit date_fits(int unsigned d, int unsigned m, int unsigned y);
      int unsigned days;
      bit leap;
      if (y < ymin || y > ymax) return 1'b0;
      if (m < 1 || m > 12) return 1'b0;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
        2:           days = leap ? 29 : 28;
        4, 6, 9, 11: days = 30;
        default:     days = 31;
      endcase
      return (d >= 1) && (d <= days);
    endfunction

    // one accepted character: advance the parser, queue a date on the last one
    function void take_char(logic [7:0] c, logic last);
      date_res_t r;
      chars++;
      if (!err) begin
        if (c == CH_SLASH) begin
          if (fld >= FLD_YEAR) begin
            fld = FLD_OVER;
            err = 1'b1;
          end else begin
            fld = fld + 2'd1;
          end
        end else if (c < CH_ZERO || c > CH_NINE) begin
          err = 1'b1;
        end else begin
          case (fld)
            FLD_DAY:   day_acc   = append_digit(day_acc, 4'(c - CH_ZERO));
            FLD_MONTH: month_acc = append_digit(month_acc, 4'(c - CH_ZERO));
            default:   year_acc  = append_digit(year_acc, 4'(c - CH_ZERO));
          endcase
        end
      end
      if (last) begin
        if (!err && date_fits(day_acc, month_acc, year_acc)) begin
          r.ok    = 1'b1;
          r.day   = day_acc[5:0];
          r.month = month_acc[4:0];
          r.year  = year_acc[14:0];
        end else begin
          r.ok    = 1'b0;
          r.day   = '1;
          r.month = '1;
          r.year  = '1;
        end
        due_dates.push_back(r);
        restart();
      end
    endfunction

    // one accepted result word against the oldest due date
    function void match_result(logic [31:0] w);
      date_res_t e;
      if (due_dates.size() == 0) begin
        $error("result word %h arrived with no date due", w);
        errors++;
        return;
      end
      e = due_dates.pop_front();
      checked++;
      if (w[0]) valid_seen++;
      if (w[0] !== e.ok) begin
        $error("valid_res expected %0d got %0d", e.ok, w[0]);
        errors++;
      end
      if (w[6:1] !== e.day) begin
        $error("day_out expected %0d got %0d", $signed(e.day), $signed(w[6:1]));
        errors++;
      end
      if (w[11:7] !== e.month) begin
        $error("month_out expected %0d got %0d", $signed(e.month), $signed(w[11:7]));
        errors++;
      end
      if (w[26:12] !== e.year) begin
        $error("year_out expected %0d got %0d", $signed(e.year), $signed(w[26:12]));
        errors++;
      end
      if (w[31:27] !== 5'd0) begin
        $error("pad bits expected 0 got %0h", w[31:27]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [13:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] char_code
  logic        s_tlast;    // last character of the string
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;    // [0] valid_res, [6:1] day_out, [11:7] month_out,
                           // [26:12] year_out, [31:27] zero

  date_tracker book;
  logic [7:0]  text[$];    // characters of the string being sent
  bit          no_idle;    // both sides run flat out while set
  int unsigned cyc;
  int unsigned strings;
  int unsigned settings;

  date_text_parser_validator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // configuration write, only while nothing is in flight
  task automatic write_bound(input logic idx, input logic [13:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_YEAR_LO) book.ymin = val;
    else book.ymax = val;
  endtask

  // offer one character, with random idle cycles in front of it unless no_idle is set
  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    book.take_char(c, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    strings++;
  endtask

  function automatic void load_text(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  // decimal digits of n, now and then with a leading zero
  function automatic void add_number(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    if ($urandom_range(0, 5) == 0) text.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  // day values around the month lengths, plus zero and overflow
  function automatic int unsigned pick_day();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 29;
      2:       return 30;
      3:       return 31;
      4:       return 32;
      5:       return $urandom_range(33, 99999);
      default: return $urandom_range(1, 28);
    endcase
  endfunction

  // february is favored so the leap rule is hit often
  function automatic int unsigned pick_month();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 13;
      2:       return $urandom_range(14, 99);
      3, 4:    return 2;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // years on the bounds, just past them, on leap multiples and saturating
  function automatic int unsigned pick_year();
    case ($urandom_range(0, 9))
      0:       return book.ymin;
      1:       return book.ymax;
      2:       return (book.ymin == 0) ? 0 : book.ymin - 1;
      3:       return book.ymax + 1;
      4:       return 400 * $urandom_range(0, 24);
      5:       return 100 * $urandom_range(0, 99);
      6:       return 4 * $urandom_range(0, 2499);
      7:       return $urandom_range(10000, 99999);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  // random string: mostly well formed dates, some broken ones, some noise
  task automatic compose_date();
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    text.delete();
    if (kind < 85) begin
      // an empty field now and then reads as zero
      if ($urandom_range(0, 32) != 0) add_number(pick_day());
      text.push_back(CH_SLASH);
      if ($urandom_range(0, 32) != 0) add_number(pick_month());
      text.push_back(CH_SLASH);
      if ($urandom_range(0, 32) != 0) add_number(pick_year());
      if (kind >= 70) begin
        // broken: a stray byte, a stray slash or a fourth field
        case ($urandom_range(0, 2))
          0:       text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
          1:       text.insert($urandom_range(0, text.size()), CH_SLASH);
          default: begin
            text.push_back(CH_SLASH);
            add_number($urandom_range(0, 99));
          end
        endcase
      end
    end else begin
      // noise of any byte value, leaning to digits and slashes
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(0, 4))
          0, 1:    text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          2:       text.push_back(CH_SLASH);
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // stop offering, wait for every due date, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (book.due_dates.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off to back up the block
  initial begin : result_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_tready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else if (!held && book.checked >= HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles - 1;
        m_tready  = 1'b0;
      end else begin
        m_tready = no_idle || ($urandom_range(0, 99) >= 8);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) book.match_result(m_tdata);
      @(negedge clk);
    end
  end

  // main sequence
  initial begin : stimulus
    logic [13:0] lo;
    logic [13:0] hi;
    book      = new();
    cyc       = 0;
    strings   = 0;
    settings  = 1;
    no_idle   = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_YEAR_LO;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      // bounds: reset values, widest, single year zero, single year 9999,
      // reversed, then random ones
      if (p > 0) begin
        case (p)
          1:       begin lo = 14'd0;    hi = 14'd9999; end
          2:       begin lo = 14'd0;    hi = 14'd0;    end
          3:       begin lo = 14'd9999; hi = 14'd9999; end
          4:       begin lo = 14'd2000; hi = 14'd1000; end
          5:       begin
            lo = 14'($urandom_range(0, 9999));
            hi = 14'($urandom_range(lo, 9999));
          end
          default: begin
            lo = 14'($urandom_range(0, 9999));
            hi = 14'($urandom_range(0, 9999));
          end
        endcase
        write_bound(REG_YEAR_LO, lo);
        write_bound(REG_YEAR_HI, hi);
        settings++;
      end
      // one setting runs with no idling on either side
      no_idle = (p == 3);

      if (p == 0) begin
        // smallest valid date under the reset bounds
        load_text("1/1/1");
        send_text();
        // leap day of a year divisible by four
        load_text("29/2/4");
        send_text();
        // third slash
        load_text("1/2/3/");
        send_text();
        // lone non-digits at both ends of the byte range
        text = '{8'hFF};
        send_text();
        text = '{8'h00};
        send_text();
        // day accumulator saturates
        load_text("99999");
        send_text();
        // all fields empty
        load_text("/");
        send_text();
      end

      begin : random_part
        int unsigned start;
        start = book.chars;
        while (book.chars - start < PhaseChars) begin
          compose_date();
          send_text();
        end
      end
      drain();
    end

    $display("covered %0d characters in %0d strings under %0d year bound settings",
             book.chars, strings, settings);
    $display("%0d result words checked, %0d of them valid dates",
             book.checked, book.valid_seen);
    if (book.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
